@@ src/fnm_pkg.sv @@
// ----------------------------------------------------------------------------
// fnm_pkg
// Shared types, constants and the case fold for the fuzzy name match scorer.
// ----------------------------------------------------------------------------
package fnm_pkg;

    localparam int QUERY_REG_CHARS = 16;
    localparam int CHAR_W          = 8;
    localparam int LEN_W           = 5;
    localparam int SCORE_W         = 3;

    typedef logic [SCORE_W-1:0] score_t;

    localparam score_t SCORE_NONE      = 3'd0;
    localparam score_t SCORE_SUBSEQ    = 3'd1;
    localparam score_t SCORE_SUBSTRING = 3'd2;
    localparam score_t SCORE_PREFIX    = 3'd3;
    localparam score_t SCORE_EXACT     = 3'd4;

    typedef enum logic [1:0] {
        CFG_QUERY_LOW    = 2'd0,
        CFG_QUERY_HIGH   = 2'd1,
        CFG_QUERY_LENGTH = 2'd2
    } cfg_index_t;

    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              name_end;
        logic              empty;
    } fnm_entry_t;

    function automatic logic [CHAR_W-1:0] fold(input logic [CHAR_W-1:0] b);
        logic [CHAR_W-1:0] r;
        r = b;
        if (b >= 8'h41 && b <= 8'h5a) begin
            r = b + 8'h20;
        end
        return r;
    endfunction

endpackage

@@ src/fuzzy_name_match_scorer.sv @@
// ----------------------------------------------------------------------------
// fuzzy_name_match_scorer
// Streams a name one character at a time and scores it against a query.
// ----------------------------------------------------------------------------
// Usage:
//   Load the query through the configuration port while the block is idle:
//   index 0 holds characters 0..7, index 1 characters 8..15 (low byte first),
//   index 2 the query length (0 = empty query, capped at 16 and QUERY_MAX).
//   Send one name character per s_ transaction; s_tlast marks the final
//   character. An empty name is one transaction with s_tuser set.
//   Each ended name gives one m_ transaction carrying the score:
//   4 exact, 3 prefix, 2 substring after the first character,
//   1 in-order subsequence or empty query, 0 no match. Case folds A-Z only.
// Timing:
//   One character per cycle sustained while no result is held back by m_tready.
//   A result passes through the queue and the result register to m_tvalid
//   and the window compare at every offset is combinational in the scoring stage.
// Reset and stalls:
//   aresetn (synchronous, active low) clears the query registers and the
//   name state. While m_tready is low the result holds, the scoring stage
//   keeps taking characters until the next name end, and the two-entry
//   queue then fills and drops s_tready.
// ----------------------------------------------------------------------------
module fuzzy_name_match_scorer #(
    parameter int QUERY_MAX = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] character
    input  logic        s_tlast,
    input  logic        s_tuser,   // [0] name_empty
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [2:0] score
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_wdata
);
    import fnm_pkg::*;

    logic [63:0] query_low_reg;
    logic [63:0] query_high_reg;
    logic [4:0]  query_len_reg;

    logic        q_push, q_full, q_pop, q_valid;
    fnm_entry_t  push_entry, pop_entry;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            query_low_reg  <= '0;
            query_high_reg <= '0;
            query_len_reg  <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_index_t'(cfg_index))
                CFG_QUERY_LOW: begin
                    query_low_reg <= cfg_wdata;
                end
                CFG_QUERY_HIGH: begin
                    query_high_reg <= cfg_wdata;
                end
                CFG_QUERY_LENGTH: begin
                    query_len_reg <= cfg_wdata[4:0];
                end
                default: begin
                end
            endcase
        end
    end

    fnm_front u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .s_tuser  (s_tuser),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_entry  (push_entry)
    );

    fnm_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_entry (push_entry),
        .full       (q_full),
        .pop        (q_pop),
        .pop_valid  (q_valid),
        .pop_entry  (pop_entry)
    );

    fnm_back #(
        .QUERY_MAX (QUERY_MAX)
    ) u_back (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .q_valid          (q_valid),
        .q_entry          (pop_entry),
        .q_pop            (q_pop),
        .query_chars_low  (query_low_reg),
        .query_chars_high (query_high_reg),
        .query_length     (query_len_reg),
        .m_tvalid         (m_tvalid),
        .m_tready         (m_tready),
        .m_tdata          (m_tdata)
    );

endmodule

@@ src/fnm_front.sv @@
// ----------------------------------------------------------------------------
// fnm_front
// Input side: takes name transactions, folds case and marks name ends.
// ----------------------------------------------------------------------------
module fnm_front (
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [7:0]                s_tdata,   // [7:0] character
    input  logic                      s_tlast,
    input  logic                      s_tuser,   // [0] name_empty
    input  logic                      q_full,
    output logic                      q_push,
    output fnm_pkg::fnm_entry_t       q_entry
);
    import fnm_pkg::*;

    assign s_tready = !q_full;
    assign q_push   = s_tvalid && !q_full;

    always_comb begin
        q_entry.ch       = fold(s_tdata);
        q_entry.empty    = s_tuser;
        q_entry.name_end = s_tlast || s_tuser;
    end

endmodule

@@ src/fnm_queue.sv @@
// ----------------------------------------------------------------------------
// fnm_queue
// Two-entry queue between the input side and the scoring side.
// ----------------------------------------------------------------------------
module fnm_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  fnm_pkg::fnm_entry_t push_entry,
    output logic                full,
    input  logic                pop,
    output logic                pop_valid,
    output fnm_pkg::fnm_entry_t pop_entry
);
    import fnm_pkg::*;

    fnm_entry_t  slot_reg [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  count_reg,  count_next;

    assign full      = (count_reg == 2'd2);
    assign pop_valid = (count_reg != 2'd0);
    assign pop_entry = slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = !wr_ptr_reg;
        end
        if (pop) begin
            rd_ptr_next = !rd_ptr_reg;
        end
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

@@ src/fnm_back.sv @@
// ----------------------------------------------------------------------------
// fnm_back
// Scoring side: shift window, prefix, substring and subsequence tracking,
// score on name end and the result register.
// ----------------------------------------------------------------------------
module fnm_back #(
    parameter int QUERY_MAX = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                q_valid,
    input  fnm_pkg::fnm_entry_t q_entry,
    output logic                q_pop,
    input  logic [63:0]         query_chars_low,
    input  logic [63:0]         query_chars_high,
    input  logic [4:0]          query_length,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [7:0]          m_tdata    // [2:0] score
);
    import fnm_pkg::*;

    localparam int SEEN_W  = $clog2(QUERY_MAX + 2);
    localparam int LEN_CAP = (QUERY_MAX < QUERY_REG_CHARS) ? QUERY_MAX : QUERY_REG_CHARS;
    localparam logic [SEEN_W-1:0] SEEN_MAX = SEEN_W'(QUERY_MAX + 1);

    logic [CHAR_W-1:0] win_reg  [QUERY_MAX];
    logic [CHAR_W-1:0] win_next [QUERY_MAX];
    logic [CHAR_W-1:0] qf       [QUERY_REG_CHARS];

    logic [SEEN_W-1:0] seen_reg, seen_next, seen_inc;
    logic              prefix_reg, prefix_next;
    logic              inner_reg, inner_next;
    logic [LEN_W-1:0]  sub_reg, sub_next;
    logic              m_valid_reg, m_valid_next;
    score_t            score_reg, score_next;

    logic [LEN_W-1:0]  len;
    logic [LEN_W-1:0]  pos;
    logic [LEN_W-1:0]  seen_upd;
    logic [LEN_W-1:0]  s_seen;
    logic [LEN_W-1:0]  s_sub;
    logic              s_prefix, s_inner;
    logic              prefix_upd, inner_upd, hit;
    logic [LEN_W-1:0]  sub_upd;
    logic [QUERY_MAX-1:0] eq;
    logic              res_push;

    assign len = (query_length > LEN_W'(LEN_CAP)) ? LEN_W'(LEN_CAP) : query_length;

    always_comb begin
        for (int k = 0; k < QUERY_REG_CHARS; k++) begin
            if (k < 8) begin
                qf[k] = fold(query_chars_low[(k % 8) * 8 +: 8]);
            end else begin
                qf[k] = fold(query_chars_high[(k % 8) * 8 +: 8]);
            end
        end
    end

    assign q_pop    = q_valid && (!q_entry.name_end || !m_valid_reg || m_tready);
    assign res_push = q_pop && q_entry.name_end;

    always_comb begin
        logic [LEN_W-1:0] idx;
        idx = '0;
        win_next[0] = q_entry.ch;
        for (int j = 1; j < QUERY_MAX; j++) begin
            win_next[j] = win_reg[j-1];
        end

        seen_inc = seen_reg;
        if (seen_reg < SEEN_MAX) begin
            seen_inc = seen_reg + SEEN_W'(1);
        end
        pos      = LEN_W'(seen_reg);
        seen_upd = LEN_W'(seen_inc);

        prefix_upd = prefix_reg;
        if (pos < len && q_entry.ch != qf[pos[3:0]]) begin
            prefix_upd = 1'b0;
        end

        for (int j = 0; j < QUERY_MAX; j++) begin
            idx   = len - LEN_W'(j) - LEN_W'(1);
            eq[j] = 1'b1;
            if (LEN_W'(j) < len) begin
                eq[j] = (win_next[j] == qf[idx[3:0]]);
            end
        end
        hit       = (len != '0) && (seen_upd > len) && (&eq);
        inner_upd = inner_reg || hit;

        sub_upd = sub_reg;
        if (sub_reg < len && q_entry.ch == qf[sub_reg[3:0]]) begin
            sub_upd = sub_reg + LEN_W'(1);
        end

        if (q_entry.empty) begin
            s_seen   = LEN_W'(seen_reg);
            s_prefix = prefix_reg;
            s_inner  = inner_reg;
            s_sub    = sub_reg;
        end else begin
            s_seen   = seen_upd;
            s_prefix = prefix_upd;
            s_inner  = inner_upd;
            s_sub    = sub_upd;
        end

        if (len == '0) begin
            score_next = SCORE_SUBSEQ;
        end else if (s_seen >= len && s_prefix) begin
            score_next = (s_seen == len) ? SCORE_EXACT : SCORE_PREFIX;
        end else if (s_seen >= len && s_inner) begin
            score_next = SCORE_SUBSTRING;
        end else begin
            score_next = (s_sub == len) ? SCORE_SUBSEQ : SCORE_NONE;
        end
        if (!res_push) begin
            score_next = score_reg;
        end

        seen_next   = seen_reg;
        prefix_next = prefix_reg;
        inner_next  = inner_reg;
        sub_next    = sub_reg;
        if (q_pop && q_entry.name_end) begin
            seen_next   = '0;
            prefix_next = 1'b1;
            inner_next  = 1'b0;
            sub_next    = '0;
        end else if (q_pop && !q_entry.empty) begin
            seen_next   = seen_inc;
            prefix_next = prefix_upd;
            inner_next  = inner_upd;
            sub_next    = sub_upd;
        end

        m_valid_next = m_valid_reg;
        if (res_push) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seen_reg    <= '0;
            prefix_reg  <= 1'b1;
            inner_reg   <= 1'b0;
            sub_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            seen_reg    <= seen_next;
            prefix_reg  <= prefix_next;
            inner_reg   <= inner_next;
            sub_reg     <= sub_next;
            m_valid_reg <= m_valid_next;
        end
        score_reg <= score_next;
    end

    always_ff @(posedge aclk) begin
        if (q_pop && !q_entry.empty) begin
            win_reg <= win_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {(8 - SCORE_W)'(0), score_reg};

`ifndef ASSERT_OFF
    a_clear_after_result : assert property (@(posedge aclk) disable iff (!aresetn)
        res_push |=> (seen_reg == '0 && prefix_reg && !inner_reg && sub_reg == '0))
        else $error("name state not cleared after result");

    a_seen_bound : assert property (@(posedge aclk) disable iff (!aresetn)
        seen_reg <= SEEN_MAX)
        else $error("character count past saturation");

    a_inner_needs_chars : assert property (@(posedge aclk) disable iff (!aresetn)
        inner_reg |-> (seen_reg >= SEEN_W'(2)))
        else $error("inner substring flagged with too few characters");

    a_prefix_needs_chars : assert property (@(posedge aclk) disable iff (!aresetn)
        !prefix_reg |-> (seen_reg != '0))
        else $error("prefix broken before any character");
`endif

endmodule
